[hw/rtl/chs_pkg.sv]
// Package with constants, payload types and state encoding of the chained hash set engine.
`timescale 1ns / 1ps
package chs_pkg;
    localparam int MaxBuckets   = 256;
    localparam int NodeCapacity = 1024;
    localparam int MaxDigits    = 16;
    localparam int HashDigits   = 10;
    localparam int BktW  = $clog2(MaxBuckets);
    localparam int NodeW = $clog2(NodeCapacity);
    localparam int PtrW  = NodeW + 1;

    localparam logic [1:0] FuncInsert   = 2'd0;
    localparam logic [1:0] FuncRemove   = 2'd1;
    localparam logic [1:0] FuncContains = 2'd2;
    localparam logic [1:0] FuncNone     = 2'd3;

    localparam logic [PtrW-1:0] NilNode = PtrW'(NodeCapacity);

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key_digits;
        logic [4:0]  key_len;
    } t_in;

    typedef struct packed {
        logic        success;
        logic [10:0] probe_steps;
        logic [10:0] entry_count;
        logic        pool_full;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_MOD, ST_HEAD, ST_HEADW, ST_NODE, ST_NODEW,
        ST_UPD, ST_POP, ST_POPW, ST_OUT
    } t_state;
endpackage

[hw/rtl/chained_hash_set_engine.sv]
// Top level of the chained hash set engine.
`timescale 1ns / 1ps
// One transaction hashes the key with one multiply-add per hashed digit (up to 10 digits), then
// starts the bit-serial bucket remainder, then walks the chain through the node memory and
// finishes with the update. After reset and after each bucket count write a clearing pass
// refills the free stack and empties the bucket heads; no transaction is accepted during it.
module chained_hash_set_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [8:0]      i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  chs_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output chs_pkg::t_out   o_out_data
);
    localparam int NW = chs_pkg::NodeW;
    localparam int PW = chs_pkg::PtrW;
    localparam int BW = chs_pkg::BktW;

    logic [PW-1:0] m_head [chs_pkg::MaxBuckets];
    logic [63:0]   m_key  [chs_pkg::NodeCapacity];
    logic [4:0]    m_len  [chs_pkg::NodeCapacity];
    logic [PW-1:0] m_next [chs_pkg::NodeCapacity];
    logic [NW-1:0] m_free [chs_pkg::NodeCapacity];

    chs_pkg::t_state r_state, n_state;
    logic [8:0]    r_bc;
    logic [NW:0]   r_clr;
    logic [1:0]    r_func;
    logic [63:0]   r_key, r_v;
    logic [4:0]    r_len;
    logic [3:0]    r_hn;
    logic [BW-1:0] r_h;
    logic [PW-1:0] r_p, r_prev, r_headv;
    logic [PW-1:0] r_ftop;
    logic [10:0]   r_cnt, r_steps;
    logic          r_found;
    logic          r_ovalid;
    chs_pkg::t_out r_out;

    logic          w_mstart, w_mdone;
    logic [8:0]    w_rem;
    logic [63:0]   rd_key;
    logic [4:0]    rd_len;
    logic [PW-1:0] rd_next, rd_head;
    logic [NW-1:0] rd_free;
    logic [4:0]    w_len;
    logic [63:0]   w_mask;

    chs_mod_unit u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_dividend(r_v), .i_divisor(r_bc), .o_done(w_mdone), .o_rem(w_rem)
    );

    assign w_len = (i_in_data.key_len > 5'd16) ? 5'd16 : i_in_data.key_len;
    always_comb begin
        w_mask = '1;
        if (w_len < 5'd16) w_mask = (64'd1 << {w_len[3:0], 2'b00}) - 64'd1;
    end

    assign o_in_ready  = (r_state == chs_pkg::ST_IDLE) && !r_ovalid && !i_cfg_we;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign w_mstart    = (r_state == chs_pkg::ST_HASH) && (r_hn == 4'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chs_pkg::ST_CLEAR: if (r_clr == (NW+1)'(chs_pkg::NodeCapacity - 1))
                                   n_state = chs_pkg::ST_IDLE;
            chs_pkg::ST_IDLE:  if (i_in_valid && o_in_ready)
                                   n_state = (i_in_data.func == chs_pkg::FuncNone) ?
                                       chs_pkg::ST_OUT : chs_pkg::ST_HASH;
            chs_pkg::ST_HASH:  if (r_hn == 4'd0) n_state = chs_pkg::ST_MOD;
            chs_pkg::ST_MOD:   if (w_mdone) n_state = chs_pkg::ST_HEAD;
            chs_pkg::ST_HEAD:  n_state = chs_pkg::ST_HEADW;
            chs_pkg::ST_HEADW: n_state = chs_pkg::ST_NODE;
            chs_pkg::ST_NODE:  n_state = r_p[NW] ? chs_pkg::ST_UPD : chs_pkg::ST_NODEW;
            chs_pkg::ST_NODEW: n_state = ((rd_len == r_len) && (rd_key == r_key)) ?
                                   chs_pkg::ST_UPD : chs_pkg::ST_NODE;
            chs_pkg::ST_UPD:   n_state = (r_func == chs_pkg::FuncInsert && !r_found &&
                                   r_ftop != '0) ? chs_pkg::ST_POP : chs_pkg::ST_OUT;
            chs_pkg::ST_POP:   n_state = chs_pkg::ST_POPW;
            chs_pkg::ST_POPW:  n_state = chs_pkg::ST_OUT;
            chs_pkg::ST_OUT:   n_state = chs_pkg::ST_IDLE;
            default:           n_state = chs_pkg::ST_IDLE;
        endcase
        if (i_cfg_we) n_state = chs_pkg::ST_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        rd_key  <= m_key[r_p[NW-1:0]];
        rd_len  <= m_len[r_p[NW-1:0]];
        rd_next <= m_next[r_p[NW-1:0]];
        rd_head <= m_head[r_h];
        rd_free <= m_free[NW'(r_ftop - PW'(1))];
        if (r_state == chs_pkg::ST_CLEAR) begin
            m_free[r_clr[NW-1:0]] <= r_clr[NW-1:0];
            if (r_clr < (NW+1)'(chs_pkg::MaxBuckets)) m_head[BW'(r_clr)] <= chs_pkg::NilNode;
        end
        if (r_state == chs_pkg::ST_UPD && r_func == chs_pkg::FuncRemove && r_found) begin
            if (r_prev[NW]) m_head[r_h] <= rd_next;
            else            m_next[r_prev[NW-1:0]] <= rd_next;
            m_free[r_ftop[NW-1:0]] <= r_p[NW-1:0];
        end
        if (r_state == chs_pkg::ST_POPW) begin
            m_key[rd_free]  <= r_key;
            m_len[rd_free]  <= r_len;
            m_next[rd_free] <= r_headv;
            m_head[r_h]     <= {1'b0, rd_free};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= chs_pkg::ST_CLEAR;
            r_bc     <= 9'd3;
            r_clr    <= '0;
            r_ftop   <= PW'(chs_pkg::NodeCapacity);
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                r_bc   <= (i_cfg_data == 9'd0) ? 9'd3 :
                          (i_cfg_data > 9'(chs_pkg::MaxBuckets)) ?
                          9'(chs_pkg::MaxBuckets) : i_cfg_data;
                r_clr  <= '0;
                r_ftop <= PW'(chs_pkg::NodeCapacity);
                r_cnt  <= '0;
            end else begin
                unique case (r_state)
                    chs_pkg::ST_CLEAR: r_clr <= r_clr + (NW+1)'(1);
                    chs_pkg::ST_IDLE: if (i_in_valid && o_in_ready) begin
                        r_func  <= i_in_data.func;
                        r_key   <= i_in_data.key_digits & w_mask;
                        r_len   <= w_len;
                        r_hn    <= (w_len > 5'd10) ? 4'd10 : w_len[3:0];
                        r_v     <= '0;
                        r_steps <= 11'd1;
                        r_prev  <= chs_pkg::NilNode;
                        r_found <= 1'b0;
                    end
                    chs_pkg::ST_HASH: if (r_hn != 4'd0) begin
                        r_v  <= r_v * 64'd131 +
                                64'(r_key[{r_hn - 4'd1, 2'b00} +: 4]) + 64'd1;
                        r_hn <= r_hn - 4'd1;
                    end
                    chs_pkg::ST_MOD: if (w_mdone) r_h <= BW'(w_rem);
                    chs_pkg::ST_HEADW: begin
                        r_p     <= rd_head;
                        r_headv <= rd_head;
                    end
                    chs_pkg::ST_NODE: if (!r_p[NW]) r_steps <= r_steps + 11'd1;
                    chs_pkg::ST_NODEW: begin
                        if ((rd_len == r_len) && (rd_key == r_key)) r_found <= 1'b1;
                        else begin
                            r_prev <= r_p;
                            r_p    <= rd_next;
                        end
                    end
                    chs_pkg::ST_UPD: begin
                        r_out.success     <= r_found && r_func != chs_pkg::FuncInsert;
                        r_out.probe_steps <= r_steps;
                        r_out.pool_full   <= r_func == chs_pkg::FuncInsert && !r_found &&
                                             r_ftop == '0;
                        if (r_func == chs_pkg::FuncRemove && r_found) begin
                            r_ftop <= r_ftop + PW'(1);
                            r_cnt  <= r_cnt - 11'd1;
                        end
                    end
                    chs_pkg::ST_POPW: begin
                        r_ftop        <= r_ftop - PW'(1);
                        r_cnt         <= r_cnt + 11'd1;
                        r_out.success <= 1'b1;
                    end
                    chs_pkg::ST_OUT: begin
                        r_ovalid          <= 1'b1;
                        r_out.entry_count <= r_cnt;
                        if (r_func == chs_pkg::FuncNone) begin
                            r_out.success     <= 1'b0;
                            r_out.probe_steps <= '0;
                            r_out.pool_full   <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

[hw/rtl/chs_mod_unit.sv]
// Restoring bit-serial 64-bit by 9-bit remainder unit.
`timescale 1ns / 1ps
module chs_mod_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [8:0]  i_divisor,
    output logic        o_done,
    output logic [8:0]  o_rem
);
    logic [63:0] r_num;
    logic [9:0]  r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [9:0]  w_sh;

    assign w_sh = {r_rem[8:0], r_num[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                r_rem <= (w_sh >= {1'b0, i_divisor}) ? w_sh - {1'b0, i_divisor} : w_sh;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_rem = r_rem[8:0];
endmodule

[tb/chs_set_checker.sv]
// Checker that predicts and compares every result of the chained hash set engine.
`timescale 1ns / 1ps
module chs_set_checker
    import chs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  [8:0] i_cfg_data,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  t_in   i_in_data,
    input  logic  i_out_valid,
    input  logic  i_out_ready,
    input  t_out  i_out_data,
    output int    o_fail_count,
    output int    o_pending
);
    int          n_buckets;
    int          chain_head[MaxBuckets];
    logic [63:0] stored_key[NodeCapacity];
    logic [4:0]  stored_len[NodeCapacity];
    int          next_node[NodeCapacity];
    int          free_nodes[NodeCapacity];
    int          free_top;
    int          key_count;
    t_out        expected_results[$];

    task automatic empty_set();
        for (int i = 0; i < MaxBuckets; i++) begin
            chain_head[i] = NilNode;
        end
        for (int i = 0; i < NodeCapacity; i++) begin
            free_nodes[i] = i;
            next_node[i] = NilNode;
        end
        free_top = NodeCapacity;
        key_count = 0;
    endtask

    function automatic t_out predict_set_op(t_in x);
        logic [4:0]  len;
        logic [63:0] key;
        logic [63:0] h;
        int          nd, bkt, p, prev, steps, node;
        bit          found;
        t_out        r;
        r = '0;
        found = 0;
        len = (x.key_len > MaxDigits) ? 5'(MaxDigits) : x.key_len;
        key = (len >= 16) ? x.key_digits : x.key_digits & ((64'd1 << (len * 4)) - 64'd1);
        if (x.func == FuncNone) begin
            r.entry_count = 11'(key_count);
            return r;
        end
        h = '0;
        nd = (len < HashDigits) ? len : HashDigits;
        for (int k = nd - 1; k >= 0; k--) begin
            h = h * 64'd131 + 64'((key >> (k * 4)) & 64'hF) + 64'd1;
        end
        bkt = int'(h % 64'(n_buckets));
        steps = 1;
        prev = NilNode;
        p = chain_head[bkt];
        while (p < NodeCapacity) begin
            steps++;
            if (stored_len[p] == len && stored_key[p] == key) begin
                found = 1;
                break;
            end
            prev = p;
            p = next_node[p];
        end
        case (x.func)
            FuncInsert: begin
                if (!found) begin
                    if (free_top == 0) begin
                        r.pool_full = 1'b1;
                    end else begin
                        free_top--;
                        node = free_nodes[free_top];
                        stored_key[node] = key;
                        stored_len[node] = len;
                        next_node[node] = chain_head[bkt];
                        chain_head[bkt] = node;
                        key_count++;
                        r.success = 1'b1;
                    end
                end
            end
            FuncRemove: begin
                if (found) begin
                    if (prev < NodeCapacity) begin
                        next_node[prev] = next_node[p];
                    end else begin
                        chain_head[bkt] = next_node[p];
                    end
                    next_node[p] = NilNode;
                    free_nodes[free_top] = p;
                    free_top++;
                    key_count--;
                    r.success = 1'b1;
                end
            end
            default: begin
                r.success = found;
            end
        endcase
        r.probe_steps = 11'(steps);
        r.entry_count = 11'(key_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            n_buckets = 3;
            empty_set();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                n_buckets = (i_cfg_data == 0) ? 3 :
                            (i_cfg_data > MaxBuckets) ? MaxBuckets : int'(i_cfg_data);
                empty_set();
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_set_op(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.success !== want.success) begin
                        $error("success: expected %0d, got %0d", want.success,
                               i_out_data.success);
                        o_fail_count++;
                    end
                    if (i_out_data.probe_steps !== want.probe_steps) begin
                        $error("probe_steps: expected %0d, got %0d", want.probe_steps,
                               i_out_data.probe_steps);
                        o_fail_count++;
                    end
                    if (i_out_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               i_out_data.entry_count);
                        o_fail_count++;
                    end
                    if (i_out_data.pool_full !== want.pool_full) begin
                        $error("pool_full: expected %0d, got %0d", want.pool_full,
                               i_out_data.pool_full);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

[tb/chained_hash_set_engine_tb.sv]
// Testbench top that drives stimulus into the chained hash set engine and reports the verdict.
`timescale 1ns / 1ps
module chained_hash_set_engine_tb;
    import chs_pkg::*;

    localparam int CycleLimit = 3000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [8:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    int         fail_count;
    int         pending;
    int         cycles;
    int         burst_left;
    bit         hold_req;
    bit         hold_done;
    logic [63:0] key_pool[32];
    logic [4:0]  len_pool[32];

    chained_hash_set_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    chs_set_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        i_out_ready <= 1'b0;
        hold_done = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_done = 1;
            end else begin
                if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    default: i_out_ready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    task automatic send_op(input logic [1:0] func, input logic [63:0] key,
                           input logic [4:0] len);
        t_in x;
        x.func = func;
        x.key_digits = key;
        x.key_len = len;
        i_in_valid <= 1'b1;
        i_in_data <= x;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_buckets(input logic [8:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_ops(input int count, input int pool_size);
        int          pick;
        logic [1:0]  func;
        logic [63:0] key;
        logic [4:0]  len;
        for (int i = 0; i < pool_size; i++) begin
            key_pool[i] = {$urandom, $urandom};
            len_pool[i] = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(8, 16));
        end
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            func = 2'($urandom_range(0, 2));
            if (pick < 5) begin
                func = FuncNone;
                key = {$urandom, $urandom};
                len = 5'($urandom);
            end else if (pick < 15) begin
                key = {$urandom, $urandom};
                len = 5'($urandom);
            end else begin
                pick = $urandom_range(0, pool_size - 1);
                key = key_pool[pick];
                len = len_pool[pick];
                if ($urandom_range(0, 3) == 0) begin
                    key = key ^ ({$urandom, $urandom} & ~((64'd1 << (len * 4)) - 64'd1));
                end
            end
            send_op(func, key, len);
        end
    endtask

    initial begin
        logic [63:0] fill_keys[1030];
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        hold_req = 0;
        burst_left = 4;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(FuncContains, 64'h0, 5'd0);
        send_op(FuncInsert, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
        send_op(FuncInsert, 64'h0, 5'd0);
        send_op(FuncContains, 64'h1234, 5'd0);
        send_op(FuncInsert, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
        send_op(FuncInsert, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
        send_op(FuncContains, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
        send_op(FuncInsert, 64'h0000_0000_0000_0000, 5'd16);
        send_op(FuncInsert, 64'hABCD_EF00_0000_0123, 5'd3);
        send_op(FuncContains, 64'h0000_0000_0000_0123, 5'd3);
        send_op(FuncInsert, 64'h9876_5432_1098_7654, 5'd12);
        send_op(FuncInsert, 64'h0000_0000_0000_0001, 5'd1);
        send_op(FuncInsert, 64'h0000_0000_0000_0004, 5'd1);
        send_op(FuncInsert, 64'h0000_0000_0000_0007, 5'd1);
        send_op(FuncContains, 64'h0000_0000_0000_0001, 5'd1);
        send_op(FuncRemove, 64'h0000_0000_0000_0004, 5'd1);
        send_op(FuncRemove, 64'h0000_0000_0000_0004, 5'd1);
        send_op(FuncNone, 64'h1111_2222_3333_4444, 5'd7);
        send_op(FuncRemove, 64'h0, 5'd0);
        send_op(FuncContains, 64'h0, 5'd0);
        send_op(FuncRemove, 64'hFFFF_FFFF_FFFF_FFFF, 5'd20);

        write_buckets(9'd1);
        random_ops(120, 30);
        write_buckets(9'd511);
        random_ops(100, 32);

        write_buckets(9'd256);
        for (int i = 0; i < 1030; i++) begin
            fill_keys[i] = {$urandom, 20'($urandom), 12'(i)};
            send_op(FuncInsert, fill_keys[i], 5'd16);
        end
        send_op(FuncInsert, fill_keys[5], 5'd16);
        send_op(FuncRemove, fill_keys[7], 5'd16);
        send_op(FuncInsert, 64'h5555_0000_1111_2222, 5'd16);
        send_op(FuncInsert, 64'h5555_0000_1111_3333, 5'd16);
        send_op(FuncContains, fill_keys[100], 5'd16);

        write_buckets(9'd0);
        hold_req = 1;
        random_ops(100, 24);
        write_buckets(9'd7);
        random_ops(80, 20);
        write_buckets(9'($urandom_range(2, 300)));
        random_ops(80, 32);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/chs_pkg.sv
hw/rtl/chs_mod_unit.sv
hw/rtl/chained_hash_set_engine.sv
tb/chs_set_checker.sv
tb/chained_hash_set_engine_tb.sv
